@@ sv/adaptive_radius_voxel_ratio_counter_assert.svh @@
// Assertion helpers used by the checker in sv/arvc_checker.sv
`ifndef ADAPTIVE_RADIUS_VOXEL_RATIO_COUNTER_ASSERT_SVH
`define ADAPTIVE_RADIUS_VOXEL_RATIO_COUNTER_ASSERT_SVH

// Checked only while out of reset
`define ARVC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked during reset as well
`define ARVC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/arvc_pkg.sv @@
package arvc_pkg;

	// Request kinds
	localparam logic [1:0] KIND_DEN   = 2'd0;
	localparam logic [1:0] KIND_NUM   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd1;

	localparam logic [30:0] BIN_WIDTH_RST = 31'd8388608;
	localparam logic [23:0] TARGET_RST    = 24'd10000;
	localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic signed [15:0] z_pos;
		logic [3:0]         voxel_x;
		logic [3:0]         voxel_y;
		logic [3:0]         voxel_z;
	} in_item_t;

	typedef struct packed {
		logic [31:0] num_count;
		logic [31:0] den_count;
		logic [7:0]  radius_bins;
		logic        clipped;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic square;
		logic sum;
		logic div_step;
		logic mem_rd;
		logic mem_wr;
		logic next_mirror;
		logic next_voxel;
		logic q_rd;
		logic q_acc;
		logic q_out;
	} arvc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic sq_last;
		logic in_range;
		logic mirror0;
		logic mirror_last;
		logic voxel_last;
		logic div_last;
		logic q_more;
		logic out_free;
	} arvc_stat_t;

endpackage

@@ sv/arvc_ctrl.sv @@
module arvc_ctrl import arvc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_kind,
	output logic       in_ready,
	input  arvc_stat_t stat,
	output arvc_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SQ, S_SUM, S_CHK, S_DIV, S_RD, S_WR, S_QRD, S_QACC, S_QDONE
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and commands
	always_comb begin
		logic adv;
		logic voxel_done;
		state_d = state_q;
		cmd     = '0;
		adv     = 1'b0;
		voxel_done = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					unique case (in_kind) inside
						KIND_DEN, KIND_NUM: state_d = S_SQ;
						KIND_QUERY:         state_d = S_QRD;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_SQ: begin
				cmd.square = 1'b1;
				if (stat.sq_last) state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.in_range) state_d = S_DIV;
				else begin
					adv        = 1'b1;
					voxel_done = stat.mirror0;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.mem_wr = 1'b1;
				adv = 1'b1;
			end
			S_QRD: begin
				cmd.q_rd = 1'b1;
				state_d = S_QACC;
			end
			S_QACC: begin
				cmd.q_acc = 1'b1;
				state_d = stat.q_more ? S_QRD : S_QDONE;
			end
			S_QDONE: begin
				if (stat.out_free) begin
					cmd.q_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// Step to the next mirror or the next voxel, or back to idle after the last voxel
		if (adv) begin
			if (voxel_done || stat.mirror_last) begin
				if (stat.voxel_last) state_d = S_IDLE;
				else begin
					cmd.next_voxel = 1'b1;
					state_d = S_SQ;
				end
			end else begin
				cmd.next_mirror = 1'b1;
				state_d = S_SUM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

endmodule

@@ sv/arvc_datapath.sv @@
module arvc_datapath import arvc_pkg::*; #(
	parameter int BINS_PER_AXIS = 16,
	parameter int DIST_BINS     = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_item_t             out_data,
	input  arvc_cmd_t             cmd,
	output arvc_stat_t            stat
);

	localparam int B_LOG  = $clog2(BINS_PER_AXIS);
	localparam int IW     = B_LOG;
	localparam int VOXELS = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
	localparam int VW     = $clog2(VOXELS);
	localparam int DEPTH  = VOXELS * DIST_BINS;
	localparam int AW     = $clog2(DEPTH);
	localparam int QB     = $clog2(DIST_BINS);
	localparam int KW     = $clog2(QB);
	localparam int NBW    = QB + 1;
	localparam int PW     = 16 + B_LOG;
	localparam int DW     = 20 + B_LOG;
	localparam int MW     = DW - 1;
	localparam int SW     = 2 * MW;
	localparam int DSW    = SW + 2;
	localparam int UW     = 31 + 2 * B_LOG;
	localparam int LW     = UW + QB + 1;
	localparam int CMPW   = (DSW > LW) ? DSW : LW;
	localparam int SUMW   = 32 + QB + 1;

	localparam logic signed [PW-1:0] B_S = PW'(BINS_PER_AXIS);
	localparam logic signed [DW-1:0] TWO = DW'(65536 * BINS_PER_AXIS);
	localparam logic [IW-1:0] IDX_MAX    = IW'(BINS_PER_AXIS - 1);

	// Voxel centre in units of 2^-15/B
	function automatic logic signed [DW-1:0] centre_f(input logic [IW-1:0] i);
		logic signed [DW-1:0] t;
		t = DW'(signed'({1'b0, i, 1'b1})) - DW'(BINS_PER_AXIS);
		return t <<< 15;
	endfunction

	function automatic logic [IW-1:0] clamp_f(input logic [3:0] v);
		logic [IW-1:0] r;
		if ({2'b00, v} >= 6'(BINS_PER_AXIS)) r = IDX_MAX;
		else                                 r = IW'(v);
		return r;
	endfunction

	function automatic logic [VW-1:0] vox_f(input logic [IW-1:0] x, input logic [IW-1:0] y,
	                                       input logic [IW-1:0] z);
		return VW'(x) + VW'(BINS_PER_AXIS) * (VW'(y) + VW'(BINS_PER_AXIS) * VW'(z));
	endfunction

	// Configuration registers
	logic [30:0] bin_width_q;
	logic [23:0] target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BIN_WIDTH_RST;
			target_q    <= TARGET_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BIN_WIDTH: bin_width_q <= cfg_data[30:0];
				REG_TARGET:    target_q    <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Bin unit and range limit
	logic [UW-1:0] unit;
	logic [LW-1:0] lim;
	assign unit = UW'((bin_width_q == '0) ? 31'd1 : bin_width_q)
	            * UW'(BINS_PER_AXIS * BINS_PER_AXIS);
	assign lim  = LW'(unit) * LW'(DIST_BINS);

	// Request registers and loop counters
	logic                   is_num_q;
	logic signed [PW-1:0]   px_q, py_q, pz_q;
	logic [AW-1:0]          qbase_q;
	logic [IW-1:0]          ix_q, iy_q, iz_q;
	logic [3:0]             sq_cnt_q;
	logic [2:0]             mir_q;
	logic [SW-1:0]          sq_q [9];
	logic [DSW-1:0]         rem_q;
	logic [QB-1:0]          quot_q;
	logic [KW-1:0]          k_q;
	logic [AW-1:0]          clr_q;
	logic [NBW-1:0]         nb_q;
	logic [SUMW-1:0]        dsum_q, nsum_q;
	logic [31:0]            rd_den_q, rd_num_q;

	// Distances along each axis: direct, mirrored at high face, mirrored at low face
	logic signed [DW-1:0] cx, cy, cz;
	logic signed [DW-1:0] diff [9];
	logic signed [DW-1:0] dsel;
	logic [MW-1:0]        mag;
	logic [SW-1:0]        sq_val;

	assign cx = centre_f(ix_q);
	assign cy = centre_f(iy_q);
	assign cz = centre_f(iz_q);

	always_comb begin
		diff[0] = DW'(px_q) - cx;
		diff[1] = DW'(px_q) + cx - TWO;
		diff[2] = DW'(px_q) + cx + TWO;
		diff[3] = DW'(py_q) - cy;
		diff[4] = DW'(py_q) + cy - TWO;
		diff[5] = DW'(py_q) + cy + TWO;
		diff[6] = DW'(pz_q) - cz;
		diff[7] = DW'(pz_q) + cz - TWO;
		diff[8] = DW'(pz_q) + cz + TWO;
	end

	assign dsel   = (sq_cnt_q <= 4'd8) ? diff[sq_cnt_q] : '0;
	assign mag    = dsel[DW-1] ? MW'(-dsel) : MW'(dsel);
	assign sq_val = SW'(mag) * SW'(mag);

	// Squared distance for the current mirror
	logic [DSW-1:0] dist_sq;
	always_comb begin
		case (mir_q)
			3'd0:    dist_sq = DSW'(sq_q[0]) + DSW'(sq_q[3]) + DSW'(sq_q[6]);
			3'd1:    dist_sq = DSW'(sq_q[1]) + DSW'(sq_q[3]) + DSW'(sq_q[6]);
			3'd2:    dist_sq = DSW'(sq_q[2]) + DSW'(sq_q[3]) + DSW'(sq_q[6]);
			3'd3:    dist_sq = DSW'(sq_q[0]) + DSW'(sq_q[4]) + DSW'(sq_q[6]);
			3'd4:    dist_sq = DSW'(sq_q[0]) + DSW'(sq_q[5]) + DSW'(sq_q[6]);
			3'd5:    dist_sq = DSW'(sq_q[0]) + DSW'(sq_q[3]) + DSW'(sq_q[7]);
			default: dist_sq = DSW'(sq_q[0]) + DSW'(sq_q[3]) + DSW'(sq_q[8]);
		endcase
	end

	logic [CMPW-1:0] trial;
	assign trial = CMPW'(unit) << k_q;

	// Memory address
	logic [AW-1:0] ev_addr, q_addr, addr;
	assign ev_addr = AW'(vox_f(ix_q, iy_q, iz_q)) * AW'(DIST_BINS) + AW'(quot_q);
	assign q_addr  = qbase_q + AW'(nb_q);
	assign addr    = cmd.clear ? clr_q : ((cmd.q_rd) ? q_addr : ev_addr);

	// Query accumulation
	logic [SUMW-1:0] dsum_n, nsum_n;
	logic [NBW-1:0]  nb_n;
	assign dsum_n = dsum_q + SUMW'(rd_den_q);
	assign nsum_n = nsum_q + SUMW'(rd_num_q);
	assign nb_n   = nb_q + NBW'(1);

	// Counter stores
	logic [31:0] den_mem [DEPTH];
	logic [31:0] num_mem [DEPTH];
	logic        we_den, we_num;
	logic [31:0] wd_den, wd_num;

	assign we_den = cmd.clear || (cmd.mem_wr && !is_num_q);
	assign we_num = cmd.clear || (cmd.mem_wr && is_num_q);
	assign wd_den = cmd.clear ? '0 : ((rd_den_q == CNT_MAX) ? CNT_MAX : rd_den_q + 32'd1);
	assign wd_num = cmd.clear ? '0 : ((rd_num_q == CNT_MAX) ? CNT_MAX : rd_num_q + 32'd1);

	always_ff @(posedge clk) begin
		if (we_den) den_mem[addr] <= wd_den;
		if (we_num) num_mem[addr] <= wd_num;
		if (cmd.mem_rd || cmd.q_rd) begin
			rd_den_q <= den_mem[addr];
			rd_num_q <= num_mem[addr];
		end
	end

	// Payload and loop registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_num_q <= (in_data.kind == KIND_NUM);
			px_q     <= PW'(in_data.x_pos) * B_S;
			py_q     <= PW'(in_data.y_pos) * B_S;
			pz_q     <= PW'(in_data.z_pos) * B_S;
			qbase_q  <= AW'(vox_f(clamp_f(in_data.voxel_x), clamp_f(in_data.voxel_y),
			                      clamp_f(in_data.voxel_z))) * AW'(DIST_BINS);
			ix_q     <= '0;
			iy_q     <= '0;
			iz_q     <= '0;
			sq_cnt_q <= '0;
			mir_q    <= '0;
			nb_q     <= '0;
			dsum_q   <= '0;
			nsum_q   <= '0;
		end
		if (cmd.square) begin
			sq_q[sq_cnt_q] <= sq_val;
			sq_cnt_q       <= sq_cnt_q + 4'd1;
		end
		if (cmd.sum) begin
			rem_q  <= dist_sq;
			quot_q <= '0;
			k_q    <= KW'(QB - 1);
		end
		// Restoring division, one quotient bit a cycle
		if (cmd.div_step) begin
			if (CMPW'(rem_q) >= trial) begin
				rem_q         <= DSW'(CMPW'(rem_q) - trial);
				quot_q[k_q]   <= 1'b1;
			end
			k_q <= k_q - KW'(1);
		end
		if (cmd.next_mirror) mir_q <= mir_q + 3'd1;
		if (cmd.next_voxel) begin
			sq_cnt_q <= '0;
			mir_q    <= '0;
			ix_q     <= (ix_q == IDX_MAX) ? '0 : ix_q + IW'(1);
			if (ix_q == IDX_MAX) begin
				iy_q <= (iy_q == IDX_MAX) ? '0 : iy_q + IW'(1);
				if (iy_q == IDX_MAX) iz_q <= iz_q + IW'(1);
			end
		end
		if (cmd.q_acc) begin
			dsum_q <= dsum_n;
			nsum_q <= nsum_n;
			nb_q   <= nb_n;
		end
	end

	// Clearing sweep and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (cmd.q_out)             out_valid <= 1'b1;
			else if (out_ready)        out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_out) begin
			out_data.clipped     <= (nsum_q > dsum_q);
			out_data.num_count   <= (nsum_q > dsum_q)
			                        ? ((dsum_q > SUMW'(CNT_MAX)) ? CNT_MAX : dsum_q[31:0])
			                        : ((nsum_q > SUMW'(CNT_MAX)) ? CNT_MAX : nsum_q[31:0]);
			out_data.den_count   <= (dsum_q > SUMW'(CNT_MAX)) ? CNT_MAX : dsum_q[31:0];
			out_data.radius_bins <= 8'(nb_q);
		end
	end

	// Status
	always_comb begin
		stat.clear_last  = (clr_q == AW'(DEPTH - 1));
		stat.sq_last     = (sq_cnt_q == 4'd8);
		stat.in_range    = (CMPW'(rem_q) < CMPW'(lim));
		stat.mirror0     = (mir_q == 3'd0);
		stat.mirror_last = (mir_q == 3'd6);
		stat.voxel_last  = (ix_q == IDX_MAX) && (iy_q == IDX_MAX) && (iz_q == IDX_MAX);
		stat.div_last    = (k_q == '0);
		stat.q_more      = (nb_n < NBW'(DIST_BINS)) && (dsum_n < SUMW'(target_q));
		stat.out_free    = !out_valid || out_ready;
	end

endmodule

@@ sv/adaptive_radius_voxel_ratio_counter.sv @@
// Voxel ratio counter with adaptive radius. After reset the block sweeps both counter
// stores to zero, one entry a cycle (BINS_PER_AXIS^3 * DIST_BINS entries, 524288 at the
// defaults), and takes no request until the sweep ends; configuration writes are taken
// at any time. An event request visits every voxel in turn: nine squarings on the single
// squaring unit, then a sum and range check for the direct distance and, if that one is
// in range, for each of the six mirrored ones; each distance in range gets a restoring
// division for log2(DIST_BINS) quotient bits plus a read and a write on the store port.
// A query reads and adds one bin at a time on the shared read port, then posts the result
// once the output register is free. Each request is accepted in the idle state. One
// request is worked at a time; a finished result waits in the output register while the
// next request is taken.
module adaptive_radius_voxel_ratio_counter import arvc_pkg::*; #(
	parameter int BINS_PER_AXIS = 16,
	parameter int DIST_BINS     = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	arvc_cmd_t  cmd;
	arvc_stat_t stat;

	assign cfg_ready = 1'b1;

	arvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	arvc_datapath #(
		.BINS_PER_AXIS (BINS_PER_AXIS),
		.DIST_BINS     (DIST_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ sv/arvc_checker.sv @@
`include "adaptive_radius_voxel_ratio_counter_assert.svh"

module arvc_sva import arvc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// Result held while stalled
	`ARVC_ASSERT(a_out_hold,
		out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
	// Clipped numerator equals denominator
	`ARVC_ASSERT(a_clip_eq,
		out_valid && out_data.clipped |-> out_data.num_count == out_data.den_count,
		"clipped result not equal")
	// Numerator never above denominator
	`ARVC_ASSERT(a_num_le_den,
		out_valid |-> out_data.num_count <= out_data.den_count, "numerator above denominator")
	// Quiet once reset has been seen
	`ARVC_ASSERT_RST(a_rst_quiet, !arst_n |=> !out_valid && !in_ready, "activity during reset")

endmodule

bind adaptive_radius_voxel_ratio_counter arvc_sva u_arvc_sva (.*);

@@ verif/arvc_checker.sv @@
`timescale 1ns / 100ps

module arvc_checker import arvc_pkg::*; #(
	parameter int BINS_PER_AXIS = 16,
	parameter int DIST_BINS     = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int  VOXELS = BINS_PER_AXIS * BINS_PER_AXIS * BINS_PER_AXIS;
	localparam longint HALF = 32768;
	localparam longint TWO  = 2 * HALF * BINS_PER_AXIS;

	// distance histograms per voxel, zero at start of simulation
	int unsigned den_hist [VOXELS * DIST_BINS];
	int unsigned num_hist [VOXELS * DIST_BINS];
	logic [30:0] bin_width  = BIN_WIDTH_RST;
	logic [23:0] target_cnt = TARGET_RST;
	out_item_t   result_q [$];

	function automatic longint centre_of(int i);
		return -HALF * BINS_PER_AXIS + longint'(2 * i + 1) * HALF;
	endfunction

	function automatic longint sqr(longint d);
		return d * d;
	endfunction

	// count one distance in a voxel's histogram, saturating
	function automatic void count_dist(bit is_num, int vox, longint d2, longint unit);
		longint bin;
		int     a;
		bin = d2 / unit;
		if (bin < DIST_BINS) begin
			a = vox * DIST_BINS + int'(bin);
			if (is_num) begin
				if (num_hist[a] != 32'hFFFF_FFFF) num_hist[a]++;
			end else begin
				if (den_hist[a] != 32'hFFFF_FFFF) den_hist[a]++;
			end
		end
	endfunction

	// an event against every voxel centre, with the six face mirrors when the direct distance is in range
	function automatic void add_point(bit is_num, in_item_t it);
		longint px, py, pz, cx, cy, cz, ax, ay, az, unit;
		int     vox;
		px   = longint'(it.x_pos) * BINS_PER_AXIS;
		py   = longint'(it.y_pos) * BINS_PER_AXIS;
		pz   = longint'(it.z_pos) * BINS_PER_AXIS;
		unit = longint'(bin_width == 0 ? 31'd1 : bin_width) * BINS_PER_AXIS * BINS_PER_AXIS;
		for (int iz = 0; iz < BINS_PER_AXIS; iz++)
			for (int iy = 0; iy < BINS_PER_AXIS; iy++)
				for (int ix = 0; ix < BINS_PER_AXIS; ix++) begin
					vox = ix + BINS_PER_AXIS * (iy + BINS_PER_AXIS * iz);
					cx  = centre_of(ix);
					cy  = centre_of(iy);
					cz  = centre_of(iz);
					ax  = sqr(px - cx);
					ay  = sqr(py - cy);
					az  = sqr(pz - cz);
					if ((ax + ay + az) / unit < DIST_BINS) begin
						count_dist(is_num, vox, ax + ay + az, unit);
						count_dist(is_num, vox, sqr(px + cx - TWO) + ay + az, unit);
						count_dist(is_num, vox, sqr(px + cx + TWO) + ay + az, unit);
						count_dist(is_num, vox, ax + sqr(py + cy - TWO) + az, unit);
						count_dist(is_num, vox, ax + sqr(py + cy + TWO) + az, unit);
						count_dist(is_num, vox, ax + ay + sqr(pz + cz - TWO), unit);
						count_dist(is_num, vox, ax + ay + sqr(pz + cz + TWO), unit);
					end
				end
	endfunction

	function automatic int clamp_axis(logic [3:0] v);
		return (int'(v) >= BINS_PER_AXIS) ? BINS_PER_AXIS - 1 : int'(v);
	endfunction

	// grow the radius until the denominator sum meets the target or all bins are summed
	function automatic out_item_t radius_query(in_item_t it);
		out_item_t r;
		longint    dsum, nsum;
		int        base, nb;
		base = (clamp_axis(it.voxel_x) + BINS_PER_AXIS * (clamp_axis(it.voxel_y)
			+ BINS_PER_AXIS * clamp_axis(it.voxel_z))) * DIST_BINS;
		dsum = den_hist[base];
		nsum = num_hist[base];
		nb   = 1;
		while (nb < DIST_BINS && dsum < longint'(target_cnt)) begin
			dsum += den_hist[base + nb];
			nsum += num_hist[base + nb];
			nb++;
		end
		r.clipped = nsum > dsum;
		if (r.clipped) nsum = dsum;
		r.den_count   = (dsum > 64'hFFFF_FFFF) ? CNT_MAX : dsum[31:0];
		r.num_count   = (nsum > 64'hFFFF_FFFF) ? CNT_MAX : nsum[31:0];
		r.radius_bins = nb[7:0];
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BIN_WIDTH) bin_width = cfg_data[30:0];
				else if (cfg_index == REG_TARGET) target_cnt = cfg_data[23:0];
			end
			// results
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: unexpected result %p", $realtime, out_data);
				end else begin
					want = result_q.pop_front();
					if (want.num_count !== out_data.num_count
						|| want.den_count !== out_data.den_count
						|| want.radius_bins !== out_data.radius_bins
						|| want.clipped !== out_data.clipped) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: mismatch expected %p got %p",
								$realtime, want, out_data);
					end
				end
			end
			// requests
			if (in_valid && in_ready) begin
				case (in_data.kind)
					KIND_DEN:   add_point(1'b0, in_data);
					KIND_NUM:   add_point(1'b1, in_data);
					KIND_QUERY: result_q = {result_q, radius_query(in_data)};
					default: ;
				endcase
			end
			pending = result_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import arvc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BIN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;

	bit quiet    = 1'b0;
	bit hold_req = 1'b0;
	bit hold_ack = 1'b0;
	logic [3:0] hit_vox [$];

	adaptive_radius_voxel_ratio_counter uut (.*);

	arvc_checker chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run guard
	initial begin
		#2_000_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send(in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// new settings only once every result is back and the block is idle
	task automatic reconfigure(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] target);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		while (!in_ready) @(negedge clk);
		repeat (10) @(negedge clk);
		write_reg(REG_BIN_WIDTH, width);
		write_reg(REG_TARGET, target);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic in_item_t point_req(logic [1:0] kind, int x, int y, int z);
		in_item_t it;
		it         = in_item_t'({$urandom, $urandom, $urandom});
		it.kind    = kind;
		it.x_pos   = x[15:0];
		it.y_pos   = y[15:0];
		it.z_pos   = z[15:0];
		return it;
	endfunction

	function automatic in_item_t voxel_req(int vx, int vy, int vz);
		in_item_t it;
		it         = in_item_t'({$urandom, $urandom, $urandom});
		it.kind    = KIND_QUERY;
		it.voxel_x = vx[3:0];
		it.voxel_y = vy[3:0];
		it.voxel_z = vz[3:0];
		return it;
	endfunction

	function automatic int near_centre(logic [3:0] v);
		return -32768 + (2 * int'(v) + 1) * 2048 + int'($urandom_range(0, 1023)) - 512;
	endfunction

	// half the requests are events clustered on voxel centres; most queries aim at those voxels
	task automatic random_phase(int n, bit calm_tail);
		in_item_t   it;
		logic [3:0] v [3];
		int         pick;
		for (int i = 0; i < n; i++) begin
			if (calm_tail && i == n - 15) quiet = 1'b1;
			if (!calm_tail && i == n / 2) begin
				hold_req = ~hold_req;
				repeat (6) send(voxel_req($urandom, $urandom, $urandom));
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				foreach (v[k]) v[k] = ($urandom_range(0, 3) == 0)
					? ($urandom_range(0, 1) ? 4'd15 : 4'd0) : 4'($urandom);
				hit_vox = {hit_vox, v[0], v[1], v[2]};
				it = point_req($urandom_range(0, 1) ? KIND_NUM : KIND_DEN,
					near_centre(v[0]), near_centre(v[1]), near_centre(v[2]));
			end else if (pick < 60) begin
				it = point_req($urandom_range(0, 1) ? KIND_NUM : KIND_DEN,
					$urandom, $urandom, $urandom);
			end else if (pick < 95) begin
				if (hit_vox.size() >= 3 && $urandom_range(0, 9) < 7) begin
					pick = 3 * $urandom_range(0, hit_vox.size() / 3 - 1);
					it = voxel_req(hit_vox[pick], hit_vox[pick + 1], hit_vox[pick + 2]);
				end else
					it = voxel_req($urandom, $urandom, $urandom);
			end else
				it = point_req(KIND_NONE, $urandom, $urandom, $urandom);
			send(it);
		end
		send(voxel_req($urandom, $urandom, $urandom));
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults after reset: extremes, clipping, unused kind
		send(point_req(KIND_DEN, 0, 0, 0));
		send(point_req(KIND_NUM, 0, 0, 0));
		send(point_req(KIND_NUM, 0, 0, 0));
		send(point_req(KIND_DEN, -32768, -32768, -32768));
		send(point_req(KIND_NUM, 32767, 32767, 32767));
		send(point_req(KIND_NONE, 0, 0, 0));
		send(voxel_req(8, 8, 8));
		send(voxel_req(7, 7, 7));
		send(voxel_req(0, 0, 0));
		send(voxel_req(15, 15, 15));

		// zero width acts as one, zero target gives one bin
		reconfigure(32'd0, 32'd0);
		send(point_req(KIND_DEN, -32768 + 7 * 2048, -32768 + 11 * 2048, -32768 + 19 * 2048));
		send(point_req(KIND_NUM, -32768 + 7 * 2048, -32768 + 11 * 2048, -32768 + 19 * 2048));
		send(voxel_req(3, 5, 9));
		send(voxel_req(8, 8, 8));

		// wide bins, largest target: every voxel and mirror counts
		reconfigure(32'd1073741824, 32'd16777215);
		send(point_req(KIND_DEN, 1234, -5000, 30000));
		send(voxel_req(0, 15, 0));
		send(voxel_req(8, 8, 8));
		send(voxel_req(15, 0, 15));

		// narrowest accepted width
		reconfigure(32'd1, 32'd1);
		send(point_req(KIND_DEN, -32768 + 2048, 30720, 0));
		send(voxel_req(0, 15, 7));

		reconfigure(32'd131072, $urandom_range(1, 4));
		random_phase(40, 1'b0);
		reconfigure($urandom_range(32768, 524288), $urandom_range(1, 6));
		random_phase(40, 1'b1);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ adaptive_radius_voxel_ratio_counter.f @@
+incdir+sv
sv/arvc_pkg.sv
sv/arvc_ctrl.sv
sv/arvc_datapath.sv
sv/adaptive_radius_voxel_ratio_counter.sv
sv/arvc_checker.sv
verif/arvc_checker.sv
verif/tb.sv
